// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Implication that must hold on the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  `ASSERT_CLK(label, clk, rst_n, (pre) |=> (post))

`endif

// ===== sv/pgfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pgfd_pkg;

  // Deque geometry.
  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int HANDLE_W = 32;

  // Port numbering and the signed port select register.
  localparam int PORT_COUNT = 3;
  localparam int PORT_W     = 2;
  localparam int SEL_W      = 3;

  // Item kinds carried in the low bits of the input tuser.
  typedef enum logic [1:0] {
    KIND_PUSH_TAIL = 2'd0,
    KIND_PUSH_HEAD = 2'd1,
    KIND_POP       = 2'd2
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push_tail;
    logic push_head;
    logic pop;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic port_match;
    logic empty;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/port_gated_frame_deque_unit.sv =====
// Port-gated frame deque: a circular deque of frame handles.
// Input stream: one beat per item. tuser selects push at tail, push at head
// or a dequeue request; tdata carries the handle and the requesting port.
// A tail push into a full deque overwrites the oldest entry; a head push into
// a full deque drops the newest entry. A dequeue request pops the head only
// when it is a get command from the port held in the port select register
// and the deque is not empty; only such a pop produces an output beat with
// the handle, the port and the count left.
// Configuration: cfg_valid_i/cfg_ready_o write the signed port select
// register (-1 selects no port); it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Throughput is one item per cycle while the receiver does not stall: each item
// changes only the head pointer, the count and one store entry. A result appears on
// the output in the cycle after the accepting edge, from the output register.
// When the receiver stalls, the result is held and a new item is taken only
// in a cycle in which the held result drains.
// Reset empties the deque and selects port 0; the store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module port_gated_frame_deque_unit import pgfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // frame_handle[31:0], request_port[33:32], zero pad
  input  logic [2:0]  s_axis_tuser_i,  // kind[1:0], request_is_get[2]
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o   // out_frame[31:0], out_port[33:32], remaining[38:34], pad
);

  ctrl_cmd_t           cmd;
  dp_status_t          status;
  logic [HANDLE_W-1:0] out_frame;
  logic [PORT_W-1:0]   out_port;
  logic [CNT_W-1:0]    out_remaining;

  assign cfg_ready_o = 1'b1;

  // Sequencing of accepts, commands and the output register.
  pgfd_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_kind_i   (kind_e'(s_axis_tuser_i[1:0])),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Store, pointers, port select and result registers.
  pgfd_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .in_handle_i     (s_axis_tdata_i[HANDLE_W-1:0]),
    .in_port_i       (s_axis_tdata_i[HANDLE_W+PORT_W-1:HANDLE_W]),
    .in_get_i        (s_axis_tuser_i[2]),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_frame_o     (out_frame),
    .out_port_o      (out_port),
    .out_remaining_o (out_remaining)
  );

  assign m_axis_tdata_o = {1'b0, out_remaining, out_port, out_frame};

endmodule

`default_nettype wire

// ===== sv/pgfd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pgfd_datapath import pgfd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [SEL_W-1:0]     cfg_data_i,
  input  logic [HANDLE_W-1:0]  in_handle_i,
  input  logic [PORT_W-1:0]    in_port_i,
  input  logic                 in_get_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  output logic [HANDLE_W-1:0]  out_frame_o,
  output logic [PORT_W-1:0]    out_port_o,
  output logic [CNT_W-1:0]     out_remaining_o
);

  logic [HANDLE_W-1:0] store_q [DEPTH];
  logic [IDX_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic signed [SEL_W-1:0] sel_q;
  logic [HANDLE_W-1:0] frame_q;
  logic [PORT_W-1:0]   port_q;
  logic [CNT_W-1:0]    remaining_q;

  logic                full;
  logic [IDX_W-1:0]    head_inc;
  logic [IDX_W-1:0]    head_dec;
  logic [IDX_W-1:0]    tail_idx;
  logic [CNT_W:0]      tail_sum;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;

  // Index arithmetic modulo the depth.
  assign full     = (count_q == CNT_W'(DEPTH));
  assign head_inc = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
  assign head_dec = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);
  assign tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
  assign tail_idx = (tail_sum >= (CNT_W+1)'(DEPTH)) ?
                    IDX_W'(tail_sum - (CNT_W+1)'(DEPTH)) : IDX_W'(tail_sum);

  // Next pointer, count and store write for the commanded operation.
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    wr_en   = 1'b0;
    wr_idx  = head_q;
    if (cmd_i.push_tail) begin
      wr_en = 1'b1;
      if (full) begin
        wr_idx = head_q;
        head_d = head_inc;
      end else begin
        wr_idx  = tail_idx;
        count_d = count_q + CNT_W'(1);
      end
    end else if (cmd_i.push_head) begin
      wr_en  = 1'b1;
      wr_idx = head_dec;
      head_d = head_dec;
      if (!full) begin
        count_d = count_q + CNT_W'(1);
      end
    end else if (cmd_i.pop) begin
      head_d  = head_inc;
      count_d = count_q - CNT_W'(1);
    end
  end

  // A request matches when it is a get command from the selected port.
  assign status_o.port_match = in_get_i && !sel_q[SEL_W-1] &&
                               (sel_q[PORT_W-1:0] < PORT_W'(PORT_COUNT)) &&
                               (in_port_i == sel_q[PORT_W-1:0]);
  assign status_o.empty      = (count_q == '0);

  // Pointer, count and port select registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      sel_q   <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        sel_q <= cfg_data_i;
      end
    end
  end

  // Entry store, written at one index per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= in_handle_i;
    end
  end

  // Result register, loaded on a pop.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      frame_q     <= store_q[head_q];
      port_q      <= in_port_i;
      remaining_q <= count_d;
    end
  end

  assign out_frame_o     = frame_q;
  assign out_port_o      = port_q;
  assign out_remaining_o = remaining_q;

endmodule

`default_nettype wire

// ===== sv/pgfd_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pgfd_controller import pgfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  kind_e      in_kind_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HOLD = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;

  // The input is taken when the result register is free or drains this cycle.
  assign in_ready_o  = (state_q == ST_IDLE) || out_ready_i;
  assign out_valid_o = (state_q == ST_HOLD);
  assign in_fire     = in_valid_i && in_ready_o;

  // Decode the accepted beat into at most one datapath command.
  always_comb begin
    cmd_o = '0;
    if (in_fire) begin
      case (in_kind_i)
        KIND_PUSH_TAIL: cmd_o.push_tail = 1'b1;
        KIND_PUSH_HEAD: cmd_o.push_head = 1'b1;
        KIND_POP:       cmd_o.pop = status_i.port_match && !status_i.empty;
        default:        cmd_o = '0;
      endcase
    end
  end

  // Output register occupancy.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.pop) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_ready_i && !cmd_o.pop) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pgfd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pgfd_checker import pgfd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);

  logic              out_stall;
  logic              in_beat;
  logic [PORT_W-1:0] out_port;
  logic [CNT_W-1:0]  out_left;

  // Handshake terms and the result fields of the output beat.
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_port  = m_axis_tdata_o[HANDLE_W +: PORT_W];
  assign out_left  = m_axis_tdata_o[HANDLE_W + PORT_W +: CNT_W];

  // A stalled output beat keeps its data.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // A new result only follows an accepted input beat.
  `ASSERT_CLK(a_out_cause, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(in_beat))

  // The input is open whenever no result is waiting.
  `ASSERT_CLK(a_in_open, clk_i, rst_ni, !m_axis_tvalid_o |-> s_axis_tready_o)

  // After a pop at least one slot is free and the port is a real one.
  `ASSERT_CLK(a_out_range, clk_i, rst_ni, m_axis_tvalid_o |-> (out_left < CNT_W'(DEPTH)) && (out_port != 2'd3))

endmodule

bind port_gated_frame_deque_unit pgfd_checker u_pgfd_checker (.*);

`default_nettype wire

// ===== tb/pgfd_delivery_checker.sv =====
`timescale 1ns / 1ps

module pgfd_delivery_checker import pgfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write channel, observed only.
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [SEL_W-1:0]  cfg_data_i,
  // Input stream, observed only.
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [39:0]       s_tdata_i,   // frame_handle[31:0], request_port[33:32], pad
  input  logic [2:0]        s_tuser_i,   // kind[1:0], request_is_get[2]
  // Output stream, observed only.
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [39:0]       m_tdata_i,   // out_frame[31:0], out_port[33:32], remaining[38:34]
  output int                fail_count_o,
  output int                pending_o
);

  // One delivered frame as the output beat carries it.
  typedef struct packed {
    logic [HANDLE_W-1:0] frame;
    logic [PORT_W-1:0]   port;
    logic [CNT_W-1:0]    left;
  } delivery_t;

  // Shadow copy of the deque and the port select register.
  logic [HANDLE_W-1:0]     slot_q [DEPTH];
  int unsigned             head_q;
  int unsigned             count_q;
  logic signed [SEL_W-1:0] port_sel_q;
  delivery_t               expected_deliveries[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  // Apply one accepted item to the shadow deque; a successful pop queues a delivery.
  task automatic apply_frame_op(input logic [1:0] kind, input logic [HANDLE_W-1:0] handle,
                                input logic [PORT_W-1:0] port, input logic is_get);
    delivery_t d;
    case (kind)
      KIND_PUSH_TAIL: begin
        if (count_q >= DEPTH) begin
          // Full: the oldest entry is overwritten and the head moves on.
          slot_q[IDX_W'(head_q)] = handle;
          head_q = (head_q + 1) % DEPTH;
        end else begin
          slot_q[IDX_W'((head_q + count_q) % DEPTH)] = handle;
          count_q++;
        end
      end
      KIND_PUSH_HEAD: begin
        // Full: the newest entry falls off the tail.
        head_q = (head_q + DEPTH - 1) % DEPTH;
        slot_q[IDX_W'(head_q)] = handle;
        if (count_q < DEPTH) count_q++;
      end
      KIND_POP: begin
        if (is_get && int'(port) < PORT_COUNT && port_sel_q >= 0 &&
            int'(port_sel_q) < PORT_COUNT && int'(port_sel_q) == int'(port) &&
            count_q != 0) begin
          d.frame = slot_q[IDX_W'(head_q)];
          head_q = (head_q + 1) % DEPTH;
          count_q--;
          d.port = port;
          d.left = count_q[CNT_W-1:0];
          expected_deliveries = {expected_deliveries, d};
        end
      end
      default: ;
    endcase
  endtask

  // Watch all three channels on each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    delivery_t got;
    delivery_t want;
    if (!rst_ni) begin
      head_q = 0;
      count_q = 0;
      port_sel_q = '0;
      expected_deliveries.delete();
    end else begin
      // Compare an output beat with the oldest expected delivery.
      if (m_tvalid_i && m_tready_i) begin
        got.frame = m_tdata_i[HANDLE_W-1:0];
        got.port  = m_tdata_i[HANDLE_W +: PORT_W];
        got.left  = m_tdata_i[HANDLE_W + PORT_W +: CNT_W];
        if (expected_deliveries.size() == 0) begin
          report_mismatch($sformatf("unexpected beat frame=%h port=%0d left=%0d",
                                    got.frame, got.port, got.left));
        end else begin
          want = expected_deliveries[0];
          expected_deliveries.delete(0);
          if (got.frame !== want.frame)
            report_mismatch($sformatf("out_frame %h, expected %h", got.frame, want.frame));
          if (got.port !== want.port)
            report_mismatch($sformatf("out_port %0d, expected %0d", got.port, want.port));
          if (got.left !== want.left)
            report_mismatch($sformatf("remaining %0d, expected %0d", got.left, want.left));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        port_sel_q = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        apply_frame_op(s_tuser_i[1:0], s_tdata_i[HANDLE_W-1:0],
                       s_tdata_i[HANDLE_W +: PORT_W], s_tuser_i[2]);
      end
    end
    pending_o = expected_deliveries.size();
  end

endmodule

// ===== tb/port_gated_frame_deque_unit_test.sv =====
`timescale 1ns / 1ps

module port_gated_frame_deque_unit_test;
  import pgfd_pkg::*;

  localparam logic [1:0]             KIND_UNUSED   = 2'd3;
  localparam logic signed [SEL_W-1:0] SEL_NONE     = -3'sd1;
  localparam int                     DRAIN_CYCLES  = 4;
  localparam int                     CYCLE_LIMIT   = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  int                      fail_count;
  int                      pending;
  int                      cycle_count = 0;
  logic signed [SEL_W-1:0] cur_sel = '0;
  int                      stall_left = 0;
  int                      stall_mode = 0;

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  port_gated_frame_deque_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  pgfd_delivery_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver stalls: modes of always ready, mostly ready, mostly stalled and a
  // periodic pattern, each held for a random stretch.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ((stall_left % 8) < 5);
    endcase
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Present one beat and hold it until the block takes it.
  task automatic send_item(input logic [1:0] kind, input logic [HANDLE_W-1:0] handle,
                           input logic [PORT_W-1:0] port, input logic is_get);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, port, handle};
    s_tuser  <= {is_get, kind};
    do @(negedge clk_i); while (!s_tready);
    @(posedge clk_i);
  endtask

  // Stop sending and wait until every expected delivery has come out. The
  // count is read at the falling edge so that it includes the last beat.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the port select register; only called while the block is idle.
  task automatic write_port_sel(input logic signed [SEL_W-1:0] sel);
    cfg_valid <= 1'b1;
    cfg_data  <= sel;
    do @(negedge clk_i); while (!cfg_ready);
    @(posedge clk_i);
    cfg_valid <= 1'b0;
    cur_sel = sel;
  endtask

  initial begin
    int                      phase;
    int                      n;
    int                      items;
    int                      push_pct;
    int                      r;
    int                      burst;
    int                      gap;
    bit                      no_gaps;
    bit                      paused;
    logic [1:0]              kind;
    logic [HANDLE_W-1:0]     handle;
    logic [PORT_W-1:0]       port;
    logic                    is_get;
    logic signed [SEL_W-1:0] next_sel;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with port 0 selected from reset.
    send_item(KIND_POP, 32'h0, 2'd0, 1'b1);                 // empty deque
    send_item(KIND_PUSH_TAIL, 32'h0000_0000, 2'd0, 1'b0);
    send_item(KIND_PUSH_TAIL, 32'hFFFF_FFFF, 2'd3, 1'b1);
    send_item(KIND_PUSH_HEAD, 32'hA5A5_A5A5, 2'd0, 1'b0);
    send_item(KIND_POP, 32'h0, 2'd0, 1'b0);                 // not a get command
    send_item(KIND_POP, 32'h0, 2'd1, 1'b1);                 // port mismatch
    send_item(KIND_POP, 32'h0, 2'd3, 1'b1);                 // nonexistent port
    send_item(KIND_UNUSED, 32'h1234_5678, 2'd0, 1'b1);      // unused kind
    send_item(KIND_POP, 32'hFFFF_FFFF, 2'd0, 1'b1);
    send_item(KIND_POP, 32'h0, 2'd0, 1'b1);
    send_item(KIND_POP, 32'h0, 2'd0, 1'b1);
    send_item(KIND_POP, 32'h0, 2'd0, 1'b1);                 // empty again
    wait_drained();

    // No port chosen: every request is ignored.
    write_port_sel(SEL_NONE);
    send_item(KIND_PUSH_TAIL, 32'h5A5A_5A5A, 2'd0, 1'b0);
    send_item(KIND_POP, 32'h0, 2'd0, 1'b1);
    send_item(KIND_POP, 32'h0, 2'd1, 1'b1);
    send_item(KIND_POP, 32'h0, 2'd2, 1'b1);
    wait_drained();

    // Highest port selected.
    write_port_sel(3'sd2);
    send_item(KIND_PUSH_HEAD, 32'h0000_0001, 2'd2, 1'b1);
    send_item(KIND_POP, 32'h0, 2'd2, 1'b1);
    send_item(KIND_POP, 32'h0, 2'd2, 1'b1);
    send_item(KIND_POP, 32'h0, 2'd2, 1'b1);
    wait_drained();

    // Random phases, each with its own port select, push mix and gap style.
    paused = 1'b0;
    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: next_sel = 3'sd2;
        1: next_sel = 3'sd1;
        2: next_sel = SEL_NONE;
        3: next_sel = 3'sd0;
        4: next_sel = 3'sd3;
        5: next_sel = -3'sd4;
        6: next_sel = 3'sd2;
        7: next_sel = -3'sd2;
        8: next_sel = 3'sd1;
        default: next_sel = 3'sd0;
      endcase
      write_port_sel(next_sel);
      push_pct = (phase % 3 == 0) ? 80 : (phase % 3 == 1) ? 50 : 30;
      no_gaps = (phase % 4 == 1);
      items = (cur_sel >= 0 && int'(cur_sel) < PORT_COUNT) ? 250 : 100;
      n = 0;
      while (n < items) begin
        burst = $urandom_range(1, 16);
        repeat (burst) begin
          if (n < items) begin
            r = $urandom_range(0, 99);
            if (r < 3) kind = KIND_UNUSED;
            else if (r < push_pct)
              kind = ($urandom_range(0, 2) == 0) ? KIND_PUSH_HEAD : KIND_PUSH_TAIL;
            else kind = KIND_POP;
            case ($urandom_range(0, 9))
              0: handle = '0;
              1: handle = '1;
              default: handle = $urandom;
            endcase
            if (cur_sel >= 0 && int'(cur_sel) < PORT_COUNT && $urandom_range(0, 9) < 8)
              port = cur_sel[PORT_W-1:0];
            else
              port = PORT_W'($urandom_range(0, 3));
            is_get = ($urandom_range(0, 9) != 0);
            send_item(kind, handle, port, is_get);
            n++;
          end
        end
        // Once, halfway through phase 3, let everything drain before going on.
        if (phase == 3 && n >= items / 2 && !paused) begin
          wait_drained();
          paused = 1'b1;
        end
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
